// ===== hdl/integer_exp_polynomial_defines.svh =====
// Assertion macros used by the checker of the integer exponential block.
// Each macro expands to one labeled concurrent assertion on the rising edge of the clock.
`ifndef INTEGER_EXP_POLYNOMIAL_DEFINES_SVH
`define INTEGER_EXP_POLYNOMIAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IEXP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/iexp_pkg.sv =====
// Shared constants and types for the integer exponential pipeline.
// Used by the divider, the top level and the checker; depends on nothing else.
package iexp_pkg;

  localparam int X0_W   = 32;                 // range reduction step
  localparam int B_W    = 31;                 // linear polynomial term
  localparam int C_W    = 62;                 // constant polynomial term
  localparam int N_W    = 6;                  // shift count
  localparam int OUT_W  = 63;                 // result width
  localparam int CFG_W  = 62;                 // widest register
  localparam int REM_W  = 32;                 // divider remainder
  localparam int R_W    = 32;                 // reduced argument and r + b
  localparam int PROD_W = 64;                 // polynomial value
  localparam int LO_W   = X0_W + N_W + 1;     // clamp bound n * x0

  typedef enum logic [1:0] {
    CFG_LN2_OVER_SCALE = 2'd0,
    CFG_POLY_B         = 2'd1,
    CFG_POLY_C         = 2'd2,
    CFG_EXP_SHIFT      = 2'd3
  } cfg_idx_t;

  localparam logic [X0_W-1:0]  X0_RESET = '1;
  localparam logic [B_W-1:0]   B_RESET  = '0;
  localparam logic [C_W-1:0]   C_RESET  = '0;
  localparam logic [N_W-1:0]   N_RESET  = N_W'(30);
  localparam logic [OUT_W-1:0] OUT_MAX  = '1;

endpackage

// ===== hdl/integer_exp_polynomial.sv =====
// Integer exponential: clamp, range reduction by x0, polynomial r*(r+b)+c, shift, saturate.
// Throughput: one beat per cycle while out_stall is low; the floor division is a pipeline
// with one quotient bit per stage, so depth grows with IN_WIDTH while the rate stays at
// one beat per cycle.
// Reset (rst_n low, synchronous) empties every stage and loads the register reset values.
// Depends on iexp_pkg and iexp_div.
module integer_exp_polynomial #(
  parameter int IN_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  iexp_pkg::cfg_idx_t            cfg_index,
  input  logic [iexp_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [IN_WIDTH-1:0]    in_x_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iexp_pkg::OUT_W-1:0]    out_exp_value
);
  import iexp_pkg::*;

  localparam int SH_W = IN_WIDTH + 2;

  // Configuration registers.
  logic signed [X0_W-1:0] x0_cfg_r;
  logic [B_W-1:0]         b_cfg_r;
  logic [C_W-1:0]         c_cfg_r;
  logic [N_W-1:0]         n_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_cfg_r <= X0_RESET;
      b_cfg_r  <= B_RESET;
      c_cfg_r  <= C_RESET;
      n_cfg_r  <= N_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LN2_OVER_SCALE: x0_cfg_r <= cfg_wdata[X0_W-1:0];
        CFG_POLY_B:         b_cfg_r  <= cfg_wdata[B_W-1:0];
        CFG_POLY_C:         c_cfg_r  <= cfg_wdata[C_W-1:0];
        CFG_EXP_SHIFT:      n_cfg_r  <= cfg_wdata[N_W-1:0];
      endcase
    end
  end

  // Values derived from the configuration, registered. The user must change the registers only
  // while the pipeline is empty (the block does not enforce it), so the register lag meets no beat.
  logic signed [X0_W-1:0] x0_eff;
  logic signed [N_W:0]    n_s;
  logic signed [LO_W-1:0] lo_nxt;
  logic signed [LO_W-1:0] lo_r;
  logic [X0_W-1:0]        d_r;

  assign x0_eff = x0_cfg_r[X0_W-1] ? x0_cfg_r : '1;
  assign n_s    = {1'b0, n_cfg_r};
  assign lo_nxt = n_s * x0_eff;

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    d_r  <= X0_W'(0) - x0_eff;
  end

  // Stall chain: each stage loads when empty or when the next one loads.
  logic rdy_out, rdy5, rdy4, rdy3, rdy2, rdy1, rdy0;
  logic div_up_ready;
  logic out_valid_r;
  logic st0_v_r, st1_v_r, st2_v_r, st3_v_r, st4_v_r, st5_v_r;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy5     = !st5_v_r || rdy_out;
  assign rdy4     = !st4_v_r || rdy5;
  assign rdy3     = !st3_v_r || rdy4;
  assign rdy2     = !st2_v_r || rdy3;
  assign rdy1     = !st1_v_r || div_up_ready;
  assign rdy0     = !st0_v_r || rdy1;
  assign in_stall = !rdy0;

  // Stage 0: input register.
  logic signed [IN_WIDTH-1:0] st0_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_v_r <= 1'b0;
    end else if (rdy0) begin
      st0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      st0_x_r <= in_x_value;
    end
  end

  // Stage 1: clamp to n * x0 and split into magnitude and sign.
  logic signed [LO_W-1:0]     x_ext;
  logic signed [IN_WIDTH-1:0] xc;
  logic [IN_WIDTH-1:0]        st1_mag_nxt;
  logic                       st1_pos_nxt;
  logic [IN_WIDTH-1:0]        st1_mag_r;
  logic                       st1_pos_r;

  assign x_ext       = LO_W'(st0_x_r);
  assign xc          = (x_ext < lo_r) ? lo_r[IN_WIDTH-1:0] : st0_x_r;
  assign st1_pos_nxt = !xc[IN_WIDTH-1] && (xc != '0);
  assign st1_mag_nxt = xc[IN_WIDTH-1] ? IN_WIDTH'(-xc) : xc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_v_r <= 1'b0;
    end else if (rdy1) begin
      st1_v_r <= st0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && st0_v_r) begin
      st1_mag_r <= st1_mag_nxt;
      st1_pos_r <= st1_pos_nxt;
    end
  end

  // Division of |x| by -x0.
  logic                dv_valid;
  logic [IN_WIDTH-1:0] dv_quot;
  logic [REM_W-1:0]    dv_rem;
  logic                dv_pos;

  iexp_div #(
    .IW (IN_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st1_v_r),
    .up_ready (div_up_ready),
    .up_mag   (st1_mag_r),
    .up_pos   (st1_pos_r),
    .divisor  (d_r),
    .dn_valid (dv_valid),
    .dn_ready (rdy2),
    .dn_quot  (dv_quot),
    .dn_rem   (dv_rem),
    .dn_pos   (dv_pos)
  );

  // Stage 2: floor quotient and remainder in (x0, 0], shift count s = n - q.
  // For a positive x the floor rounds away from zero, so a nonzero
  // remainder bumps the quotient and folds the remainder below zero.
  logic                 round_up;
  logic [SH_W-1:0]      qadj;
  logic [SH_W-1:0]      sfull;
  logic [REM_W:0]       r_wide;
  logic signed [R_W-1:0] st2_r_r;
  logic                 st2_sat_r;
  logic [N_W-1:0]       st2_sh_r;

  assign round_up = dv_pos && (dv_rem != '0);
  assign qadj     = SH_W'(dv_quot) + SH_W'(round_up);
  assign sfull    = dv_pos ? SH_W'(n_cfg_r) + qadj : SH_W'(n_cfg_r) - qadj;
  assign r_wide   = round_up ? {1'b0, dv_rem} - {1'b0, d_r}
                             : {(REM_W + 1){1'b0}} - {1'b0, dv_rem};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
    end else if (rdy2) begin
      st2_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && dv_valid) begin
      st2_r_r   <= r_wide[R_W-1:0];
      st2_sat_r <= sfull >= SH_W'(OUT_W);
      st2_sh_r  <= sfull[N_W-1:0];
    end
  end

  // Stage 3: r + b. With r <= 0 and b >= 0 the sum stays inside R_W bits.
  logic signed [R_W:0]   t_wide;
  logic signed [R_W-1:0] st3_r_r;
  logic signed [R_W-1:0] st3_t_r;
  logic                  st3_sat_r;
  logic [N_W-1:0]        st3_sh_r;

  assign t_wide = {st2_r_r[R_W-1], st2_r_r} + $signed({{(R_W + 1 - B_W){1'b0}}, b_cfg_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st3_v_r <= 1'b0;
    end else if (rdy3) begin
      st3_v_r <= st2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && st2_v_r) begin
      st3_r_r   <= st2_r_r;
      st3_t_r   <= t_wide[R_W-1:0];
      st3_sat_r <= st2_sat_r;
      st3_sh_r  <= st2_sh_r;
    end
  end

  // Stage 4: r * (r + b).
  logic signed [PROD_W-1:0] p_nxt;
  logic signed [PROD_W-1:0] st4_p_r;
  logic                     st4_sat_r;
  logic [N_W-1:0]           st4_sh_r;

  assign p_nxt = st3_r_r * st3_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_v_r <= 1'b0;
    end else if (rdy4) begin
      st4_v_r <= st3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && st3_v_r) begin
      st4_p_r   <= p_nxt;
      st4_sat_r <= st3_sat_r;
      st4_sh_r  <= st3_sh_r;
    end
  end

  // Stage 5: add the constant term.
  logic signed [PROD_W-1:0] z_nxt;
  logic signed [PROD_W-1:0] st5_z_r;
  logic                     st5_sat_r;
  logic [N_W-1:0]           st5_sh_r;

  assign z_nxt = st4_p_r + $signed({{(PROD_W - C_W){1'b0}}, c_cfg_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st5_v_r <= 1'b0;
    end else if (rdy5) begin
      st5_v_r <= st4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && st4_v_r) begin
      st5_z_r   <= z_nxt;
      st5_sat_r <= st4_sat_r;
      st5_sh_r  <= st4_sh_r;
    end
  end

  // Output stage: shift left by s, saturating when any bit leaves the word; zero when z <= 0.
  logic                   z_pos;
  logic [2*OUT_W-1:0]     shifted;
  logic                   over;
  logic [OUT_W-1:0]       res_nxt;
  logic [OUT_W-1:0]       out_exp_r;

  assign z_pos   = !st5_z_r[PROD_W-1] && (st5_z_r != '0);
  assign shifted = {{OUT_W{1'b0}}, st5_z_r[OUT_W-1:0]} << st5_sh_r;
  assign over    = |shifted[2*OUT_W-1:OUT_W];

  always_comb begin
    priority if (!z_pos) begin
      res_nxt = '0;
    end else if (st5_sat_r || over) begin
      res_nxt = OUT_MAX;
    end else begin
      res_nxt = shifted[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= st5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && st5_v_r) begin
      out_exp_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_exp_value = out_exp_r;

endmodule

// ===== hdl/iexp_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on iexp_pkg; instantiated by integer_exp_polynomial.
module iexp_div #(
  parameter int IW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [IW-1:0]               up_mag,
  input  logic                        up_pos,
  input  logic [iexp_pkg::X0_W-1:0]   divisor,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [IW-1:0]               dn_quot,
  output logic [iexp_pkg::REM_W-1:0]  dn_rem,
  output logic                        dn_pos
);
  import iexp_pkg::*;

  logic             v_r    [IW];
  logic             pos_r  [IW];
  logic [IW-1:0]    num_r  [IW];
  logic [IW-1:0]    quot_r [IW];
  logic [REM_W-1:0] rem_r  [IW];
  logic [IW:0]      rdy;

  // A stage can load when it is empty or when everything after it moves.
  always_comb begin
    rdy[IW] = dn_ready;
    for (int j = IW - 1; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end

  for (genvar j = 0; j < IW; j++) begin : g_stage
    logic             src_v;
    logic             src_pos;
    logic [IW-1:0]    src_num;
    logic [IW-1:0]    src_quot;
    logic [REM_W-1:0] src_rem;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             take;

    if (j == 0) begin : g_first
      assign src_v    = up_valid;
      assign src_pos  = up_pos;
      assign src_num  = up_mag;
      assign src_quot = '0;
      assign src_rem  = '0;
    end else begin : g_next
      assign src_v    = v_r[j-1];
      assign src_pos  = pos_r[j-1];
      assign src_num  = num_r[j-1];
      assign src_quot = quot_r[j-1];
      assign src_rem  = rem_r[j-1];
    end

    assign trial = {src_rem, src_num[IW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign take  = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && src_v) begin
        pos_r[j]  <= src_pos;
        num_r[j]  <= src_num << 1;
        quot_r[j] <= {src_quot[IW-2:0], take};
        rem_r[j]  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[IW-1];
  assign dn_quot  = quot_r[IW-1];
  assign dn_rem   = rem_r[IW-1];
  assign dn_pos   = pos_r[IW-1];

endmodule

// ===== hdl/iexp_chk.sv =====
// Port-level checker for integer_exp_polynomial, attached with bind.
// Depends on iexp_pkg and the assertion macros in integer_exp_polynomial_defines.svh.
`include "integer_exp_polynomial_defines.svh"

module iexp_chk #(
  parameter int IN_WIDTH = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [iexp_pkg::OUT_W-1:0]  out_exp_value
);
  import iexp_pkg::*;

  // Every stage holds at most one beat.
  localparam int DEPTH  = IN_WIDTH + 7;
  localparam int PEND_W = $clog2(DEPTH + 1);

  logic              in_acc;
  logic              out_acc;
  logic [PEND_W-1:0] pend_r;
  logic [PEND_W-1:0] pend_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign pend_nxt = pend_r + PEND_W'(in_acc) - PEND_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `IEXP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_exp_value), "stalled result beat changed or dropped")
  `IEXP_ASSERT_SAME(a_reset_empty, clk, rst_n, $rose(rst_n), !out_valid, "result beat present right after reset")
  `IEXP_ASSERT_SAME(a_free_input, clk, rst_n, !out_valid || !out_stall, !in_stall, "input stalled while the output side can move")
  `IEXP_ASSERT_SAME(a_occupancy, clk, rst_n, out_valid, pend_r != '0 && pend_r <= PEND_W'(DEPTH), "result beat without a matching input beat or pipeline overfilled")

endmodule

bind integer_exp_polynomial iexp_chk #(
  .IN_WIDTH (IN_WIDTH)
) u_iexp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_exp_value (out_exp_value)
);
